// File: hdl/seeded_random_in_range_core_macros.svh
// Assertion macros shared by the seeded random-in-range block.
// Depends on nothing; included by the modules that assert.
`ifndef SEEDED_RANDOM_IN_RANGE_CORE_MACROS_SVH
`define SEEDED_RANDOM_IN_RANGE_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define SRR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define SRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/srr_pkg.sv
// Package of the seeded random-in-range block: widths, constants, seed table.
// Depends on nothing.
package srr_pkg;
  localparam int unsigned WordW  = 32;
  localparam int unsigned DrawW  = 28;
  localparam int unsigned Cells  = DrawW;
  localparam logic [16:0] LcgMult = 17'd69069;

  typedef struct packed {
    logic [WordW-1:0] seed_value;
    logic [WordW-1:0] range_low;
    logic [WordW-1:0] range_high;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0] random_value;
  } rsp_t;

  // One stage of the remainder chain.
  typedef struct packed {
    logic             vld;
    logic [WordW:0]   rem;
    logic [DrawW-1:0] quo_bits;
    logic [WordW-1:0] span;
    logic [WordW-1:0] low;
    logic             one;
    logic             zero;
    logic [DrawW-1:0] draw;
  } cell_t;

  function automatic logic [14:0] seed_tab(input logic [7:0] idx);
    logic [14:0] t [256];
    t = '{
      15'd28985,15'd27138,15'd26457,15'd9451,15'd17764,15'd10909,15'd28790,15'd8716,
      15'd6361,15'd4853,15'd17798,15'd21977,15'd19643,15'd20662,15'd10834,15'd20103,
      15'd27067,15'd28634,15'd18623,15'd25849,15'd8576,15'd26234,15'd23887,15'd18228,
      15'd32587,15'd4836,15'd3306,15'd1811,15'd3035,15'd24559,15'd18399,15'd315,
      15'd26766,15'd907,15'd24102,15'd12370,15'd9674,15'd2972,15'd10472,15'd16492,
      15'd22683,15'd11529,15'd27968,15'd30406,15'd13213,15'd2319,15'd23620,15'd16823,
      15'd10013,15'd23772,15'd21567,15'd1251,15'd19579,15'd20313,15'd18241,15'd30130,
      15'd8402,15'd20807,15'd27354,15'd7169,15'd21211,15'd17293,15'd5410,15'd19223,
      15'd10255,15'd22480,15'd27388,15'd9946,15'd15628,15'd24389,15'd17308,15'd2370,
      15'd9530,15'd31683,15'd25927,15'd23567,15'd11694,15'd26397,15'd32602,15'd15031,
      15'd18255,15'd17582,15'd1422,15'd28835,15'd23607,15'd12597,15'd20602,15'd10138,
      15'd5212,15'd1252,15'd10074,15'd23166,15'd19823,15'd31667,15'd5902,15'd24630,
      15'd18948,15'd14330,15'd14950,15'd8939,15'd23540,15'd21311,15'd22428,15'd22391,
      15'd3583,15'd29004,15'd30498,15'd18714,15'd4278,15'd2437,15'd22430,15'd3439,
      15'd28313,15'd23161,15'd25396,15'd13471,15'd19324,15'd15287,15'd2563,15'd18901,
      15'd13103,15'd16867,15'd9714,15'd14322,15'd15197,15'd26889,15'd19372,15'd26241,
      15'd31925,15'd14640,15'd11497,15'd8941,15'd10056,15'd6451,15'd28656,15'd10737,
      15'd13874,15'd17356,15'd8281,15'd25937,15'd1661,15'd4850,15'd7448,15'd12744,
      15'd21826,15'd5477,15'd10167,15'd16705,15'd26897,15'd8839,15'd30947,15'd27978,
      15'd27283,15'd24685,15'd32298,15'd3525,15'd12398,15'd28726,15'd9475,15'd10208,
      15'd617,15'd13467,15'd22287,15'd2376,15'd6097,15'd26312,15'd2974,15'd9114,
      15'd21787,15'd28010,15'd4725,15'd15387,15'd3274,15'd10762,15'd31695,15'd17320,
      15'd18324,15'd12441,15'd16801,15'd27376,15'd22464,15'd7500,15'd5666,15'd18144,
      15'd15314,15'd31914,15'd31627,15'd6495,15'd5226,15'd31203,15'd2331,15'd4668,
      15'd12650,15'd18275,15'd351,15'd7268,15'd31319,15'd30119,15'd7600,15'd2905,
      15'd13826,15'd11343,15'd13053,15'd15583,15'd30055,15'd31093,15'd5067,15'd761,
      15'd9685,15'd11070,15'd21369,15'd27155,15'd3663,15'd26542,15'd20169,15'd12161,
      15'd15411,15'd30401,15'd7580,15'd31784,15'd8985,15'd29367,15'd20989,15'd14203,
      15'd29694,15'd21167,15'd10337,15'd1706,15'd28578,15'd887,15'd3373,15'd19477,
      15'd14382,15'd675,15'd7033,15'd15111,15'd26138,15'd12252,15'd30996,15'd21409,
      15'd25678,15'd18555,15'd13256,15'd23316,15'd22407,15'd16727,15'd991,15'd9236,
      15'd5373,15'd29402,15'd6117,15'd15241,15'd27715,15'd19291,15'd19888,15'd19847
    };
    return t[idx];
  endfunction
endpackage

// File: hdl/srr_if.sv
// Valid/ready channel carrying one payload of type T.
// Depends on nothing; instantiated with package types.
interface srr_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/srr_cell.sv
// One restoring-remainder cell: handles one draw bit, shift and subtract.
// Depends on srr_pkg.
module srr_cell
  import srr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cell_t cell_i,
  output cell_t cell_o
);
  // Bit index handled is carried implicitly: the draw bits enter MSB first.
  cell_t       cell_d, cell_q;
  logic [WordW:0] shifted;

  always_comb begin
    cell_d   = cell_i;
    shifted  = {cell_i.rem[WordW-1:0], cell_i.quo_bits[DrawW-1]};
    cell_d.quo_bits = {cell_i.quo_bits[DrawW-2:0], 1'b0};
    if (shifted >= {1'b0, cell_i.span}) begin
      cell_d.rem = shifted - {1'b0, cell_i.span};
    end else begin
      cell_d.rem = shifted;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;
endmodule

// File: hdl/srr_front.sv
// Front stages: table lookup, multiply by 69069, second lookup, draw.
// Depends on srr_pkg and the assertion macros.
`include "seeded_random_in_range_core_macros.svh"
module srr_front
  import srr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  req_t  req_i,
  output cell_t cell_o
);
  // Stage 1: first table word.
  logic             s1_vld_q;
  logic [14:0]      s1_word_q;
  logic [WordW-1:0] s1_low_q, s1_span_q;
  // Stage 2: product.
  logic             s2_vld_q;
  logic [WordW-1:0] s2_prod_q, s2_low_q, s2_span_q;
  logic [WordW-1:0] idx_sum, span_d, prod_d, word2;
  logic [DrawW-1:0] draw;

  assign idx_sum = req_i.seed_value + req_i.range_low + req_i.range_high;
  assign span_d  = req_i.range_high - req_i.range_low + 32'd1;
  assign prod_d  = WordW'({17'd0, s1_word_q} * {15'd0, LcgMult});
  assign word2   = s2_prod_q + {17'd0, seed_tab(s2_prod_q[7:0])} + 32'd1;
  assign draw    = word2[DrawW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      cell_o   <= '0;
    end else if (en_i) begin
      s1_vld_q        <= vld_i;
      s2_vld_q        <= s1_vld_q;
      cell_o.vld      <= s2_vld_q;
      cell_o.rem      <= '0;
      cell_o.quo_bits <= draw;
      cell_o.draw     <= draw;
      cell_o.span     <= s2_span_q;
      cell_o.low      <= s2_low_q;
      cell_o.one      <= (s2_span_q == 32'd1);
      cell_o.zero     <= (s2_span_q == 32'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_word_q <= seed_tab(idx_sum[7:0]);
      s1_low_q  <= req_i.range_low;
      s1_span_q <= span_d;
      s2_prod_q <= prod_d;
      s2_low_q  <= s1_low_q;
      s2_span_q <= s1_span_q;
    end
  end

  `SRR_ASSERT_NEXT(a_s1_to_s2, clk_i, rst_ni, en_i && s1_vld_q, s2_vld_q)
  `SRR_ASSERT_NEXT(a_s2_to_out, clk_i, rst_ni, en_i && s2_vld_q, cell_o.vld)
  `SRR_ASSERT_IMP(a_flags_excl, clk_i, rst_ni, cell_o.vld, !(cell_o.one && cell_o.zero))
endmodule

// File: hdl/seeded_random_in_range_core.sv
// Top level of the seeded random-in-range block.
// Depends on srr_pkg, srr_if, srr_front, srr_cell and the assertion macros.
//
// Usage: each request on req carries a seed and signed low/high bounds; the
// block answers one signed value on rsp, low plus the draw modulo the span.
// Requests are independent, so one request is taken every cycle unless stalled.
// Pipeline: 3 front stages (table, multiply, second table) then one cell
// per draw bit (28 cells), plus one output register.
// Throughput: one request per cycle unless stalled; 28 remainder cells
// set most of the latency, each holding one request's partial remainder.
// Stalls: the whole pipe advances only when the output register is free or
// being drained, so req.ready drops as soon as a response waits on a
// stalled rsp, and the whole pipe holds until it is taken.
// Reset clears all valid flags; the pipe is empty after reset.
// Special cases: a span of one returns low; a span that wraps to zero
// returns low plus the raw draw.
`include "seeded_random_in_range_core_macros.svh"
module seeded_random_in_range_core
  import srr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  srr_if.sink   req,
  srr_if.source rsp
);
  logic         en;
  cell_t        chain [Cells+1];
  logic         out_vld_q;
  logic [WordW-1:0] out_val_q, offset;
  req_t         req_data;
  rsp_t         rsp_data;

  // Pipe advances when the output slot is empty or being taken.
  assign en        = !out_vld_q || rsp.ready;
  assign req.ready = en;
  assign req_data  = req.data;

  srr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (req.valid),
    .req_i  (req_data),
    .cell_o (chain[0])
  );

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    srr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  always_comb begin
    priority if (chain[Cells].one) begin
      offset = '0;
    end else if (chain[Cells].zero) begin
      offset = {{(WordW-DrawW){1'b0}}, chain[Cells].draw};
    end else begin
      offset = chain[Cells].rem[WordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= chain[Cells].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_val_q <= chain[Cells].low + offset;
    end
  end

  assign rsp_data.random_value = out_val_q;
  assign rsp.valid = out_vld_q;
  assign rsp.data  = rsp_data;

  `SRR_ASSERT_IMP(a_stall_ready, clk_i, rst_ni, out_vld_q && !rsp.ready, !req.ready)
  `SRR_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_vld_q && !rsp.ready, $stable(out_val_q))
  `SRR_ASSERT_NEXT(a_last_to_out, clk_i, rst_ni, en && chain[Cells].vld, out_vld_q)
endmodule
